// ----- rtl/skt_pkg.sv -----
// Shared types and constants for the sorted key table.
package skt_pkg;

   localparam int CMD_W    = 2;
   localparam int KEY_IN_W = 32;
   localparam int KEY_MAX_W = 64;
   localparam int POS_W    = 10;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_SHIFT,
      ST_PUT,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/sorted_key_table.sv -----
// Sorted key table: binary-search insert and lookup over a one-write, one-read key memory.
//
// The block keeps up to TABLE_DEPTH keys in ascending order in one memory with one
// write port and one registered read port, driven by a small sequencer. Each
// binary-search probe costs a memory read and a compare. Clear, an unused command
// and an insert into a full table skip the search. An insert runs its search to the
// end, as an insert never stops on a match, and then moves every stored entry above
// the insert position up by one, one entry per cycle through the read port, before
// it writes the new key. No new item is taken while one is in progress. A finished
// result waits in the output register while the next item is taken; while that
// register still holds an unsent result, the next result waits in the done state.
// The memory needs no clearing after reset.
module sorted_key_table #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_WIDTH   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [skt_pkg::KEY_IN_W-1:0]      req_tdata,  // key
   input  logic [skt_pkg::CMD_W-1:0]         req_tuser,  // command
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,  // position, zero pad
   output logic [1:0]                        rsp_tuser   // table_full, found
);
   import skt_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   state_type state_ff, state_in;

   logic [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];
   logic [KEY_WIDTH-1:0] rd_data_ff;
   logic                 mem_re, mem_we;
   logic [ADDR_W-1:0]    mem_raddr, mem_waddr;
   logic [KEY_WIDTH-1:0] mem_wdata;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [ADDR_W-1:0]    mid_ff, mid_in, sh_ff, sh_in, wa_ff, wa_in;
   logic                 pend_ff, pend_in;
   logic                 ins_ff, ins_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [ADDR_W-1:0]    res_pos_ff, res_pos_in;
   logic                 res_found_ff, res_found_in, res_full_ff, res_full_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic                 rsp_found_ff, rsp_found_in, rsp_full_ff, rsp_full_in;

   logic                 req_acc, load_rsp, is_full, lo_lt_hi, key_lt, key_gt;
   logic [CNT_W:0]       mid_sum;
   logic [ADDR_W-1:0]    mid_calc;
   logic [KEY_MAX_W-1:0] key_wide;
   logic [ADDR_W+POS_W-1:0] pos_wide;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign load_rsp   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign is_full    = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign lo_lt_hi   = (lo_ff < hi_ff);
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff} - (CNT_W+1)'(1);
   assign mid_calc   = mid_sum[ADDR_W:1];
   assign key_lt     = (key_ff < rd_data_ff);
   assign key_gt     = (key_ff > rd_data_ff);
   assign key_wide   = KEY_MAX_W'(req_tdata);
   assign pos_wide   = {{POS_W{1'b0}}, res_pos_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if ((req_tuser == CMD_INSERT && !is_full) || req_tuser == CMD_SEARCH) begin
                  state_in = ST_PROBE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_PROBE: begin
            if (lo_lt_hi) begin
               state_in = ST_CMP;
            end else if (ins_ff) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CMP: begin
            if (!ins_ff && !key_lt && !key_gt) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_SHIFT: begin
            if (sh_ff <= res_pos_ff) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT:  state_in = ST_DONE;
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      sh_in        = sh_ff;
      wa_in        = wa_ff;
      pend_in      = 1'b0;
      ins_in       = ins_ff;
      key_in       = key_ff;
      res_pos_in   = res_pos_ff;
      res_found_in = res_found_ff;
      res_full_in  = res_full_ff;
      mem_re       = 1'b0;
      mem_raddr    = mid_calc;
      mem_we       = 1'b0;
      mem_waddr    = wa_ff;
      mem_wdata    = rd_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               key_in       = key_wide[KEY_WIDTH-1:0];
               ins_in       = (req_tuser == CMD_INSERT);
               lo_in        = '0;
               hi_in        = count_ff;
               res_pos_in   = '0;
               res_found_in = 1'b0;
               res_full_in  = (req_tuser == CMD_INSERT) && is_full;
               if (req_tuser == CMD_CLEAR) begin
                  count_in = '0;
               end
            end
         end
         ST_PROBE: begin
            if (lo_lt_hi) begin
               mem_re = 1'b1;
               mid_in = mid_calc;
            end else if (ins_ff) begin
               res_pos_in = lo_ff[ADDR_W-1:0];
               sh_in      = count_ff[ADDR_W-1:0];
            end
         end
         ST_CMP: begin
            if (key_lt) begin
               hi_in = CNT_W'(mid_ff);
            end else if (ins_ff || key_gt) begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end else begin
               res_pos_in   = mid_ff;
               res_found_in = 1'b1;
            end
         end
         ST_SHIFT: begin
            mem_we = pend_ff;
            if (sh_ff > res_pos_ff) begin
               mem_re    = 1'b1;
               mem_raddr = sh_ff - ADDR_W'(1);
               wa_in     = sh_ff;
               pend_in   = 1'b1;
               sh_in     = sh_ff - ADDR_W'(1);
            end
         end
         ST_PUT: begin
            mem_we       = 1'b1;
            mem_waddr    = res_pos_ff;
            mem_wdata    = key_ff;
            count_in     = count_ff + CNT_W'(1);
            res_found_in = 1'b1;
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = pos_wide[POS_W-1:0];
         rsp_found_in = res_found_ff;
         rsp_full_in  = res_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= key_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      sh_ff        <= sh_in;
      wa_ff        <= wa_in;
      ins_ff       <= ins_in;
      key_ff       <= key_in;
      res_pos_ff   <= res_pos_in;
      res_found_ff <= res_found_in;
      res_full_ff  <= res_full_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16-POS_W){1'b0}}, rsp_pos_ff};
   assign rsp_tuser  = {rsp_full_ff, rsp_found_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   a_pend_in_shift: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == ST_SHIFT)
      else $error("pending shift write outside shift phase");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser == CMD_CLEAR) |=> count_ff == '0)
      else $error("clear did not empty the table");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the table by one");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for sorted_key_table: directed, full-table, backpressure and random traffic.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import skt_pkg::*;

   localparam int          TABLE_DEPTH     = 1024;
   localparam int          KEY_WIDTH       = 32;
   localparam logic [1:0]  CMD_UNUSED      = 2'd3;
   localparam int          RSP_HOLD_CYCLES = 2500;
   localparam int          SETTLE_CYCLES   = 1200;
   localparam int          RANDOM_ITEMS    = 570;
   localparam int          MAX_REPORTS     = 10;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             found;
      logic             table_full;
   } table_answer_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [KEY_IN_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]    req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;
   logic [1:0]          rsp_tuser;

   logic [KEY_IN_W-1:0] shelf_keys [TABLE_DEPTH];
   int unsigned         shelf_count = 0;
   table_answer_type    awaited_results [$];

   int burst_left = 0;
   int fail_count = 0;
   int reports_shown = 0;
   int results_checked = 0;
   int n_insert = 0, n_search = 0, n_clear = 0, n_unused = 0;
   int n_refused = 0, n_hits = 0, deepest_fill = 0;

   int hold_asked = 0, hold_served = 0, hold_left = 0;
   int stall_mode = 0, mode_left = 0, rx_cycle = 0;

   sorted_key_table #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .KEY_WIDTH  (KEY_WIDTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic table_answer_type apply_table_op(input logic [CMD_W-1:0] op,
                                                       input logic [KEY_IN_W-1:0] key);
      table_answer_type ans;
      int unsigned      lo, hi, mid, idx;
      ans = '0;
      case (op)
         CMD_INSERT: begin
            n_insert++;
            if (shelf_count >= TABLE_DEPTH) begin
               ans.table_full = 1'b1;
               n_refused++;
            end else begin
               lo = 0;
               hi = shelf_count;
               while (lo < hi) begin
                  mid = (lo + hi - 1) / 2;
                  if (key < shelf_keys[mid]) hi = mid;
                  else lo = mid + 1;
               end
               for (idx = shelf_count; idx > lo; idx--) shelf_keys[idx] = shelf_keys[idx-1];
               shelf_keys[lo] = key;
               shelf_count++;
               if (shelf_count > deepest_fill) deepest_fill = shelf_count;
               ans.position = lo[POS_W-1:0];
               ans.found    = 1'b1;
            end
         end
         CMD_SEARCH: begin
            n_search++;
            lo = 0;
            hi = shelf_count;
            while (lo < hi && !ans.found) begin
               mid = (lo + hi - 1) / 2;
               if (key < shelf_keys[mid]) hi = mid;
               else if (key > shelf_keys[mid]) lo = mid + 1;
               else begin
                  ans.found    = 1'b1;
                  ans.position = mid[POS_W-1:0];
                  n_hits++;
               end
            end
         end
         CMD_CLEAR: begin
            n_clear++;
            shelf_count = 0;
         end
         default: n_unused++;
      endcase
      return ans;
   endfunction

   task automatic send_item(input logic [CMD_W-1:0] op, input logic [KEY_IN_W-1:0] key);
      table_answer_type ans;
      int               gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 1);
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= key;
      do @(posedge clock); while (!req_tready);
      ans = apply_table_op(op, key);
      awaited_results = {awaited_results, ans};
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   // response side: random stall modes, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_asked != hold_served || hold_left > 0) begin
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = RSP_HOLD_CYCLES;
         end
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (mode_left == 0) begin
            stall_mode = $urandom_range(3, 0);
            mode_left  = $urandom_range(300, 40);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(1, 0));
            2: rsp_tready <= ($urandom_range(3, 0) == 0);
            default: rsp_tready <= (rx_cycle % 8 < 5);
         endcase
      end
   end

   always @(posedge clock) begin
      table_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (awaited_results.size() == 0) begin
            fail_count++;
            if (reports_shown < MAX_REPORTS) begin
               reports_shown++;
               $display("tb: unexpected item data=%h user=%b", rsp_tdata, rsp_tuser);
            end
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tdata !== {6'd0, want.position} ||
                rsp_tuser !== {want.table_full, want.found}) begin
               fail_count++;
               if (reports_shown < MAX_REPORTS) begin
                  reports_shown++;
                  $display("tb: mismatch position exp %0d got %0d, found exp %b got %b,",
                           want.position, rsp_tdata[POS_W-1:0], want.found, rsp_tuser[0]);
                  $display("tb:    full exp %b got %b (data %h)",
                           want.table_full, rsp_tuser[1], rsp_tdata);
               end
            end
         end
      end
   end

   task automatic test_directed_cases();
      send_item(CMD_SEARCH, 32'h0000_0000);
      send_item(CMD_SEARCH, 32'hFFFF_FFFF);
      send_item(CMD_CLEAR,  32'h0000_0000);
      send_item(CMD_UNUSED, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 32'd500);
      send_item(CMD_INSERT, 32'h0000_0000);
      send_item(CMD_INSERT, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, 32'd500);
      send_item(CMD_INSERT, 32'd500);
      send_item(CMD_SEARCH, 32'd500);
      send_item(CMD_SEARCH, 32'h0000_0000);
      send_item(CMD_SEARCH, 32'hFFFF_FFFF);
      send_item(CMD_SEARCH, 32'd499);
      send_item(CMD_SEARCH, 32'd501);
      send_item(CMD_UNUSED, 32'd500);
      send_item(CMD_SEARCH, 32'd500);
      send_item(CMD_INSERT, 32'hFFFF_FFFE);
      send_item(CMD_INSERT, 32'd1);
      send_item(CMD_CLEAR,  32'hFFFF_FFFF);
      send_item(CMD_SEARCH, 32'd500);
      send_item(CMD_INSERT, 32'hAAAA_AAAA);
      send_item(CMD_INSERT, 32'h5555_5555);
      send_item(CMD_SEARCH, 32'h5555_5555);
      send_item(CMD_CLEAR,  32'h0000_0000);
      wait_drained();
   endtask

   task automatic test_fill_to_capacity();
      logic [KEY_IN_W-1:0] next_key;
      int                  i;
      next_key = 32'h0000_1000;
      send_item(CMD_CLEAR, $urandom());
      // ascending keys keep the shifts short; a few small keys at the end shift the whole table
      for (i = 0; i < TABLE_DEPTH - 4; i++) begin
         next_key += $urandom_range(3, 0);
         send_item(CMD_INSERT, next_key);
      end
      for (i = 0; i < 4; i++) send_item(CMD_INSERT, 32'h0000_0000);
      send_item(CMD_INSERT, 32'h0000_0000);
      send_item(CMD_INSERT, 32'hFFFF_FFFF);
      send_item(CMD_INSERT, $urandom());
      send_item(CMD_SEARCH, 32'h0000_0000);
      send_item(CMD_SEARCH, next_key);
      send_item(CMD_SEARCH, 32'hFFFF_FFFF);
      for (i = 0; i < 6; i++) send_item(CMD_SEARCH, shelf_keys[$urandom_range(TABLE_DEPTH-1, 0)]);
      send_item(CMD_UNUSED, $urandom());
      send_item(CMD_INSERT, next_key);
      send_item(CMD_CLEAR,  $urandom());
      send_item(CMD_SEARCH, next_key);
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      int i;
      hold_asked++;
      for (i = 0; i < 40; i++) begin
         if (i % 3 == 0 || shelf_count == 0) send_item(CMD_INSERT, $urandom());
         else send_item(CMD_SEARCH, shelf_keys[$urandom_range(shelf_count-1, 0)]);
      end
      wait_drained();
   endtask

   task automatic test_random_traffic();
      logic [CMD_W-1:0]    op;
      logic [KEY_IN_W-1:0] key;
      int                  i, r;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         r = $urandom_range(99, 0);
         if (r < 50) op = CMD_INSERT;
         else if (r < 93) op = CMD_SEARCH;
         else if (r < 98) op = CMD_UNUSED;
         else op = CMD_CLEAR;
         case ($urandom_range(9, 0))
            0, 1, 2: key = (shelf_count > 0) ? shelf_keys[$urandom_range(shelf_count-1, 0)]
                                             : $urandom();
            6:       key = $urandom_range(15, 0);
            7: begin
               case ($urandom_range(3, 0))
                  0: key = 32'h0000_0000;
                  1: key = 32'h0000_0001;
                  2: key = 32'hFFFF_FFFE;
                  default: key = 32'hFFFF_FFFF;
               endcase
            end
            8: begin
               key = (shelf_count > 0) ? shelf_keys[$urandom_range(shelf_count-1, 0)]
                                       : $urandom();
               key = $urandom_range(1, 0) ? key + 1 : key - 1;
            end
            9:       key = 32'd1 << $urandom_range(31, 0);
            default: key = $urandom();
         endcase
         send_item(op, key);
         if (i % 100 == 99) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_fill_to_capacity();
      test_output_backpressure();
      test_random_traffic();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         fail_count += awaited_results.size();
         $display("tb: %0d results never arrived", awaited_results.size());
      end
      $display("tb: ran %0d inserts (%0d refused when full), %0d searches (%0d hits),",
               n_insert, n_refused, n_search, n_hits);
      $display("tb:    %0d clears, %0d unused codes", n_clear, n_unused);
      $display("tb: table reached %0d entries; %0d results checked, %0d failures",
               deepest_fill, results_checked, fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(64'd100_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule
